### rtl/core/bpdlr_pkg.sv
// Package for the button pad debouncer: register map, reset values and the
// packed per-button state that the block reports.
// Depends on nothing; used by button_pad_debounce_latch_repeat.
`default_nettype none

package bpdlr_pkg;

    // Default number of buttons on the pad.
    localparam int NUM_BUTTONS_DEF = 5;

    // Widths of the time stamp, the millisecond settings and the APB port.
    localparam int TIME_W = 32;
    localparam int MS_W   = 16;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 4;

    // Reset values of the timing registers.
    localparam logic [MS_W-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [MS_W-1:0] REPEAT_RESET   = 16'd700;

    // Register index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_DEBOUNCE   = 2'd0,
        REG_REPEAT     = 2'd1,
        REG_LATCHABLE  = 2'd2,
        REG_ACTIVE_LOW = 2'd3
    } cfg_reg_t;

    // Reported state of one button.
    typedef struct packed {
        logic raw_cur;
        logic repeating;
        logic changed;
        logic latched;
        logic pressed;
    } snap_t;

endpackage

`default_nettype wire

### rtl/core/button_pad_debounce_latch_repeat.sv
// Button pad debouncer with toggle latch, hold-repeat flag and one active button.
// Uses bpdlr_pkg for the register map, reset values and the snap_t state type.
// Single module: input register, per-button update logic, result register.
`default_nettype none

// Usage:
// Each input transfer carries one sample of all raw button levels (raw_levels)
// and a free-running millisecond time stamp (now_ms). Every input transfer
// yields exactly one output transfer: the active button index (NUM_BUTTONS
// means none) and its pressed, latched, changed, repeat and raw flags.
// The sample is captured in an input register; from there the debounce,
// latch and repeat update of the sampled buttons runs through one level of
// parallel compare logic into the result register, so each result passes
// the input register and then the result register. Throughput is one sample
// per cycle while the receiver accepts, set by the single update pass over
// the per-button state registers.
// When the receiver stalls, the result register holds its transfer and the
// input register fills; in_ready then follows out_ready combinationally.
// Reset clears all button state, marks no button active and loads the
// register defaults (debounce 50 ms, repeat 700 ms, masks zero).
// The APB port (pready always high) writes and reads the four registers at
// byte addresses 0, 4, 8 and 12; write it only while the block is idle.
module button_pad_debounce_latch_repeat #(
    parameter int NUM_BUTTONS = bpdlr_pkg::NUM_BUTTONS_DEF,
    localparam int IDX_W = $clog2(NUM_BUTTONS + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // APB configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bpdlr_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [bpdlr_pkg::DATA_W-1:0]  pwdata,
    output logic      [bpdlr_pkg::DATA_W-1:0]  prdata,
    output logic                               pready,
    // Sample input channel
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [NUM_BUTTONS-1:0]        raw_levels,
    input  wire logic [bpdlr_pkg::TIME_W-1:0]  now_ms,
    // Result output channel
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [IDX_W-1:0]              active_button,
    output logic                               is_pressed,
    output logic                               is_latched,
    output logic                               just_changed,
    output logic                               is_repeating,
    output logic                               raw_current
);

    localparam logic [IDX_W-1:0] IDX_NONE = IDX_W'(NUM_BUTTONS);
    localparam int TIME_W = bpdlr_pkg::TIME_W;
    localparam int MS_W   = bpdlr_pkg::MS_W;
    localparam int DATA_W = bpdlr_pkg::DATA_W;

    // Configuration registers
    logic [MS_W-1:0]         debounce_ms_reg;
    logic [MS_W-1:0]         repeat_ms_reg;
    logic [NUM_BUTTONS-1:0]  latchable_mask_reg;
    logic [NUM_BUTTONS-1:0]  active_low_mask_reg;
    bpdlr_pkg::cfg_reg_t     cfg_index;
    logic                    cfg_write;

    // Input register
    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic [NUM_BUTTONS-1:0]  s1_raw_reg;
    logic [TIME_W-1:0]       s1_now_reg;
    logic                    s1_advance;
    logic                    in_xfer;

    // Per-button state
    logic [NUM_BUTTONS-1:0]  raw_seen_reg;
    logic [NUM_BUTTONS-1:0]  raw_seen_next;
    logic [NUM_BUTTONS-1:0]  debounced_reg;
    logic [NUM_BUTTONS-1:0]  debounced_next;
    logic [NUM_BUTTONS-1:0]  latch_reg;
    logic [NUM_BUTTONS-1:0]  latch_next;
    logic [NUM_BUTTONS-1:0]  repeat_reg;
    logic [NUM_BUTTONS-1:0]  repeat_next;
    logic [NUM_BUTTONS-1:0]  changed_now;
    logic [TIME_W-1:0]       change_time_reg  [NUM_BUTTONS];
    logic [TIME_W-1:0]       change_time_next [NUM_BUTTONS];
    logic [TIME_W-1:0]       held_ms          [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0]  level_now;
    logic [NUM_BUTTONS-1:0]  sampled;

    // Active button tracking
    logic [IDX_W-1:0]        active_index_reg;
    logic [IDX_W-1:0]        active_index_next;
    bpdlr_pkg::snap_t        snapshot_reg;
    bpdlr_pkg::snap_t        snapshot_next;
    bpdlr_pkg::snap_t        button_snap [NUM_BUTTONS];
    logic [IDX_W-1:0]        report_index;
    logic                    none_active;

    // Result register
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [IDX_W-1:0]        out_index_reg;
    bpdlr_pkg::snap_t        out_snap_reg;

    // APB decode: writes land in the access cycle.
    assign pready    = 1'b1;
    assign cfg_index = bpdlr_pkg::cfg_reg_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg     <= bpdlr_pkg::DEBOUNCE_RESET;
            repeat_ms_reg       <= bpdlr_pkg::REPEAT_RESET;
            latchable_mask_reg  <= '0;
            active_low_mask_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bpdlr_pkg::REG_DEBOUNCE:   debounce_ms_reg     <= pwdata[MS_W-1:0];
                bpdlr_pkg::REG_REPEAT:     repeat_ms_reg       <= pwdata[MS_W-1:0];
                bpdlr_pkg::REG_LATCHABLE:  latchable_mask_reg  <= pwdata[NUM_BUTTONS-1:0];
                bpdlr_pkg::REG_ACTIVE_LOW: active_low_mask_reg <= pwdata[NUM_BUTTONS-1:0];
                default:                   debounce_ms_reg     <= debounce_ms_reg;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (cfg_index)
            bpdlr_pkg::REG_DEBOUNCE:
                prdata = {{(DATA_W-MS_W){1'b0}}, debounce_ms_reg};
            bpdlr_pkg::REG_REPEAT:
                prdata = {{(DATA_W-MS_W){1'b0}}, repeat_ms_reg};
            bpdlr_pkg::REG_LATCHABLE:
                prdata = {{(DATA_W-NUM_BUTTONS){1'b0}}, latchable_mask_reg};
            bpdlr_pkg::REG_ACTIVE_LOW:
                prdata = {{(DATA_W-NUM_BUTTONS){1'b0}}, active_low_mask_reg};
            default:
                prdata = '0;
        endcase
    end

    // Handshake: the input register moves on when the result register is free.
    assign s1_advance     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready       = !s1_valid_reg || s1_advance;
    assign in_xfer        = in_valid && in_ready;
    assign s1_valid_next  = in_xfer || (s1_valid_reg && !s1_advance);
    assign out_valid_next = s1_advance || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the sample on an input transfer.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_raw_reg <= raw_levels;
            s1_now_reg <= now_ms;
        end
    end

    // Per-button update: each button is sampled while none is active, or
    // when it is the active one.
    assign none_active = (active_index_reg == IDX_NONE);

    always_comb
    begin
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            level_now[i] = s1_raw_reg[i] ^ active_low_mask_reg[i];
            sampled[i]   = none_active || (active_index_reg == IDX_W'(i));

            raw_seen_next[i]    = raw_seen_reg[i];
            change_time_next[i] = change_time_reg[i];
            debounced_next[i]   = debounced_reg[i];
            latch_next[i]       = latch_reg[i];
            repeat_next[i]      = repeat_reg[i];
            changed_now[i]      = 1'b0;

            if (sampled[i] && (level_now[i] != raw_seen_reg[i]))
            begin
                raw_seen_next[i]    = level_now[i];
                change_time_next[i] = s1_now_reg;
            end
            held_ms[i] = s1_now_reg - change_time_next[i];

            if (sampled[i])
            begin
                if ((raw_seen_next[i] != debounced_reg[i]) &&
                    (held_ms[i] > {{(TIME_W-MS_W){1'b0}}, debounce_ms_reg}))
                begin
                    if (raw_seen_next[i] && latchable_mask_reg[i])
                    begin
                        latch_next[i] = !latch_reg[i];
                    end
                    debounced_next[i] = raw_seen_next[i];
                    repeat_next[i]    = 1'b0;
                    changed_now[i]    = 1'b1;
                end
                else if (debounced_reg[i] &&
                         (held_ms[i] > {{(TIME_W-MS_W){1'b0}}, repeat_ms_reg}))
                begin
                    repeat_next[i] = 1'b1;
                end
            end

            button_snap[i].pressed   = debounced_next[i];
            button_snap[i].latched   = latch_next[i];
            button_snap[i].changed   = changed_now[i];
            button_snap[i].repeating = repeat_next[i];
            button_snap[i].raw_cur   = raw_seen_next[i];
        end
    end

    // Pick the reported button: the active one, else the highest new press.
    always_comb
    begin
        report_index  = active_index_reg;
        snapshot_next = snapshot_reg;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            if (none_active)
            begin
                if (changed_now[i] && debounced_next[i])
                begin
                    report_index  = IDX_W'(i);
                    snapshot_next = button_snap[i];
                end
            end
            else if (active_index_reg == IDX_W'(i))
            begin
                snapshot_next = button_snap[i];
            end
        end

        // A reported release frees the active slot for the next sample.
        if ((report_index != IDX_NONE) && snapshot_next.changed && !snapshot_next.pressed)
        begin
            active_index_next = IDX_NONE;
        end
        else
        begin
            active_index_next = report_index;
        end
    end

    // Button state registers, updated once per sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_seen_reg     <= '0;
            debounced_reg    <= '0;
            latch_reg        <= '0;
            repeat_reg       <= '0;
            active_index_reg <= IDX_NONE;
            snapshot_reg     <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                change_time_reg[i] <= '0;
            end
        end
        else if (s1_advance)
        begin
            raw_seen_reg     <= raw_seen_next;
            debounced_reg    <= debounced_next;
            latch_reg        <= latch_next;
            repeat_reg       <= repeat_next;
            active_index_reg <= active_index_next;
            snapshot_reg     <= snapshot_next;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                change_time_reg[i] <= change_time_next[i];
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_index_reg <= report_index;
            out_snap_reg  <= snapshot_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign active_button = out_index_reg;
    assign is_pressed    = out_snap_reg.pressed;
    assign is_latched    = out_snap_reg.latched;
    assign just_changed  = out_snap_reg.changed;
    assign is_repeating  = out_snap_reg.repeating;
    assign raw_current   = out_snap_reg.raw_cur;

endmodule

`default_nettype wire

### test/tb_button_pad_debounce_latch_repeat.sv
// Self-checking testbench for button_pad_debounce_latch_repeat.
// Predicts every report from a local model of the debounce, latch and repeat state;
// depends on bpdlr_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_button_pad_debounce_latch_repeat;

    localparam int NBTN = bpdlr_pkg::NUM_BUTTONS_DEF;
    localparam int TIME_W = bpdlr_pkg::TIME_W;
    localparam int MS_W = bpdlr_pkg::MS_W;
    localparam int DATA_W = bpdlr_pkg::DATA_W;
    localparam int ADDR_W = bpdlr_pkg::ADDR_W;
    localparam logic [2:0] NO_BUTTON = 3'(NBTN);
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD_AT = 420;
    localparam int LONG_HOLD_CYCLES = 300;

    // One sample of the pad as offered on the input channel.
    typedef struct packed {
        logic [NBTN-1:0]   raw;
        logic [TIME_W-1:0] now;
    } pad_sample_t;

    // One report as expected on the output channel.
    typedef struct packed {
        logic [2:0]       button;
        bpdlr_pkg::snap_t state;
    } pad_report_t;

    // Clock, reset and block ports.
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [NBTN-1:0] raw_levels = '0;
    logic [TIME_W-1:0] now_ms = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0] active_button;
    logic is_pressed;
    logic is_latched;
    logic just_changed;
    logic is_repeating;
    logic raw_current;

    // Stimulus and expectation stores.
    pad_sample_t pending_samples[$];
    pad_report_t expected_reports[$];

    // Local copy of the register settings.
    logic [MS_W-1:0] cfg_debounce = bpdlr_pkg::DEBOUNCE_RESET;
    logic [MS_W-1:0] cfg_repeat = bpdlr_pkg::REPEAT_RESET;
    logic [NBTN-1:0] cfg_latchable = '0;
    logic [NBTN-1:0] cfg_active_low = '0;

    // Local copy of the per-button state and the active button.
    logic [NBTN-1:0] seen_level = '0;
    logic [NBTN-1:0] accepted_level = '0;
    logic [NBTN-1:0] toggle_latch = '0;
    logic [NBTN-1:0] repeat_flag = '0;
    logic [TIME_W-1:0] last_edge_time [NBTN];
    logic [2:0] active_idx = NO_BUTTON;
    bpdlr_pkg::snap_t last_snap = '0;

    // Pacing and bookkeeping.
    int error_count = 0;
    int reports_seen = 0;
    int cycle_count = 0;
    int burst_left = 1;
    int gap_left = 0;
    int hold_left = 0;
    logic long_hold_done = 1'b0;
    logic sender_steady = 1'b0;
    logic sink_steady = 1'b0;

    // Generator state: logical press state of each button and the running time.
    logic [NBTN-1:0] gen_pressed = '0;
    logic [TIME_W-1:0] gen_time = '0;

    button_pad_debounce_latch_repeat #(
        .NUM_BUTTONS(NBTN)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .raw_levels(raw_levels),
        .now_ms(now_ms),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .active_button(active_button),
        .is_pressed(is_pressed),
        .is_latched(is_latched),
        .just_changed(just_changed),
        .is_repeating(is_repeating),
        .raw_current(raw_current)
    );

    always #1 clk = ~clk;

    // Update one button from a sample and return its reported state.
    function automatic bpdlr_pkg::snap_t update_button(input int i,
                                                       input logic [NBTN-1:0] raw,
                                                       input logic [TIME_W-1:0] now);
        logic lvl;
        logic [TIME_W-1:0] held;
        bpdlr_pkg::snap_t s;
        s = '0;
        lvl = raw[i] ^ cfg_active_low[i];
        if (lvl != seen_level[i])
        begin
            last_edge_time[i] = now;
            seen_level[i] = lvl;
        end
        held = now - last_edge_time[i];
        if (seen_level[i] != accepted_level[i] && held > TIME_W'(cfg_debounce))
        begin
            if (seen_level[i] && cfg_latchable[i])
                toggle_latch[i] = ~toggle_latch[i];
            accepted_level[i] = seen_level[i];
            repeat_flag[i] = 1'b0;
            s.changed = 1'b1;
        end
        else if (accepted_level[i] && held > TIME_W'(cfg_repeat))
        begin
            repeat_flag[i] = 1'b1;
        end
        s.pressed = accepted_level[i];
        s.latched = toggle_latch[i];
        s.repeating = repeat_flag[i];
        s.raw_cur = seen_level[i];
        return s;
    endfunction

    // Work out the report for an accepted sample and queue it.
    task automatic predict_report(input logic [NBTN-1:0] raw, input logic [TIME_W-1:0] now);
        bpdlr_pkg::snap_t s;
        pad_report_t rep;
        if (active_idx != NO_BUTTON)
        begin
            last_snap = update_button(int'(active_idx), raw, now);
        end
        else
        begin
            // All buttons are updated; the highest new press wins.
            for (int i = 0; i < NBTN; i++)
            begin
                s = update_button(i, raw, now);
                if (s.changed && s.pressed)
                begin
                    active_idx = 3'(i);
                    last_snap = s;
                end
            end
        end
        rep.button = active_idx;
        rep.state = last_snap;
        expected_reports.push_back(rep);
        // A reported release frees the pad for the next sample.
        if (active_idx != NO_BUTTON && last_snap.changed && !last_snap.pressed)
            active_idx = NO_BUTTON;
    endtask

    // Register write over APB: setup cycle, then access cycle.
    task automatic cfg_write(input bpdlr_pkg::cfg_reg_t idx, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            bpdlr_pkg::REG_DEBOUNCE:   cfg_debounce = value[MS_W-1:0];
            bpdlr_pkg::REG_REPEAT:     cfg_repeat = value[MS_W-1:0];
            bpdlr_pkg::REG_LATCHABLE:  cfg_latchable = value[NBTN-1:0];
            bpdlr_pkg::REG_ACTIVE_LOW: cfg_active_low = value[NBTN-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int deb, input int rpt, input int latch, input int alow);
        cfg_write(bpdlr_pkg::REG_DEBOUNCE, DATA_W'(deb));
        cfg_write(bpdlr_pkg::REG_REPEAT, DATA_W'(rpt));
        cfg_write(bpdlr_pkg::REG_LATCHABLE, DATA_W'(latch));
        cfg_write(bpdlr_pkg::REG_ACTIVE_LOW, DATA_W'(alow));
    endtask

    task automatic queue_sample(input logic [NBTN-1:0] raw, input logic [TIME_W-1:0] now);
        pad_sample_t smp;
        smp.raw = raw;
        smp.now = now;
        pending_samples.push_back(smp);
    endtask

    // Random press and release sequences with bounce and noise on top.
    task automatic queue_random_samples(input int count);
        int span;
        int pick;
        int k;
        logic [NBTN-1:0] noise;
        span = (int'(cfg_debounce) > int'(cfg_repeat) / 4) ? int'(cfg_debounce)
                                                            : int'(cfg_repeat) / 4;
        span = span / 3 + 2;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            noise = '0;
            k = $urandom_range(0, NBTN - 1);
            if (pick < 8)
                gen_pressed[k] = ~gen_pressed[k];
            else if (pick < 16)
                noise[k] = 1'b1;
            else if (pick < 18)
                noise = NBTN'($urandom_range(0, (1 << NBTN) - 1));
            if ($urandom_range(0, 199) == 0)
                gen_time = gen_time + $urandom();
            else
                gen_time = gen_time + $urandom_range(0, span);
            queue_sample(gen_pressed ^ cfg_active_low ^ noise, gen_time);
        end
    endtask

    // Return at a falling edge once nothing is queued, offered or outstanding.
    task automatic wait_drained();
        @(negedge clk);
        while (pending_samples.size() != 0 || in_valid || expected_reports.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(input string field, input logic [2:0] want,
                               input logic [2:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // Input driver: offers samples in bursts, holding each until its transfer.
    always @(posedge clk)
    begin : drive_samples
        pad_sample_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_report(raw_levels, now_ms);
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0 && !sender_steady)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    nxt = pending_samples.pop_front();
                    in_valid <= 1'b1;
                    raw_levels <= nxt.raw;
                    now_ms <= nxt.now;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: short random stalls, and one long hold-off to back up the block.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (!long_hold_done && reports_seen >= LONG_HOLD_AT)
        begin
            long_hold_done <= 1'b1;
            hold_left <= LONG_HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (sink_steady || $urandom_range(0, 3) != 0)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            hold_left <= $urandom_range(0, 5);
            out_ready <= 1'b0;
        end
    end

    // Monitor: each output transfer is checked against the oldest expected report.
    always @(posedge clk)
    begin : check_reports
        pad_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            reports_seen <= reports_seen + 1;
            if (expected_reports.size() == 0)
            begin
                error_count++;
                $display("%0t: report with none expected, actual button %0d", $time,
                         active_button);
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("active_button", want.button, active_button);
                check_field("is_pressed", 3'(want.state.pressed), 3'(is_pressed));
                check_field("is_latched", 3'(want.state.latched), 3'(is_latched));
                check_field("just_changed", 3'(want.state.changed), 3'(just_changed));
                check_field("is_repeating", 3'(want.state.repeating), 3'(is_repeating));
                check_field("raw_current", 3'(want.state.raw_cur), 3'(raw_current));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : run_test
        for (int i = 0; i < NBTN; i++)
            last_edge_time[i] = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: strict debounce edge, highest press wins, repeat while held,
        // release of the active button, snapshot kept while idle, time wrap.
        queue_sample(5'b00000, 32'd0);
        queue_sample(5'b11111, 32'd10);
        queue_sample(5'b11111, 32'd60);
        queue_sample(5'b11111, 32'd61);
        queue_sample(5'b11111, 32'd761);
        queue_sample(5'b01111, 32'd762);
        queue_sample(5'b01111, 32'd813);
        queue_sample(5'b01111, 32'd900);
        queue_sample(5'b00000, 32'd1000);
        queue_sample(5'b00000, 32'd1051);
        queue_sample(5'b00011, 32'd1100);
        queue_sample(5'b00011, 32'd1200);
        queue_sample(5'b00001, 32'd1210);
        queue_sample(5'b00001, 32'd1300);
        queue_sample(5'b00001, 32'hFFFF_FFF0);
        queue_sample(5'b10001, 32'hFFFF_FFF0);
        queue_sample(5'b10001, 32'h0000_0023);
        queue_sample(5'b10000, 32'h0000_0040);
        queue_sample(5'b10000, 32'h0000_0080);

        // Zero hold times, every button latchable, mixed polarity.
        wait_drained();
        set_config(0, 0, 5'b11111, 5'b10101);
        @(negedge clk);
        queue_sample(5'b10101, 32'd5);
        queue_sample(5'b01010, 32'd6);
        queue_sample(5'b01010, 32'd7);
        queue_sample(5'b10101, 32'd8);
        queue_sample(5'b10101, 32'd8);
        queue_sample(5'b10101, 32'd9);

        // Random phases, each under its own settings.
        for (int ph = 0; ph < 6; ph++)
        begin
            wait_drained();
            case (ph)
                0: set_config(20, 300, $urandom_range(0, 31), $urandom_range(0, 31));
                1: set_config(0, 0, 31, 31);
                2: set_config(65535, 65535, 0, 0);
                3: set_config(0, 65535, $urandom_range(0, 31), $urandom_range(0, 31));
                4: set_config(65535, 0, $urandom_range(0, 31), $urandom_range(0, 31));
                default: set_config($urandom_range(0, 400), $urandom_range(0, 2000),
                                    $urandom_range(0, 31), $urandom_range(0, 31));
            endcase
            @(negedge clk);
            sender_steady = (ph == 2);
            sink_steady = (ph == 2 || ph == 4);
            // Start one phase just short of the time wrap.
            if (ph == 3)
                gen_time = 32'hFFFF_0000 + $urandom_range(0, 32'hFFFF);
            queue_random_samples(170);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
rtl/core/bpdlr_pkg.sv
rtl/core/button_pad_debounce_latch_repeat.sv
test/tb_button_pad_debounce_latch_repeat.sv
